FILE: sv/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; every other file imports this package.
package pps_pkg;

  // Size of the process table
  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // One input transaction
  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic        ran;
    logic [3:0]  run_slot;
    logic        finished;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic        all_done;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_en;
    logic scan_clr;
    logic scan_step;
    logic update_en;
    logic finish_en;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;
  } dp_sts_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

endpackage

FILE: sv/pps_ctrl.sv
// Sequencing state machine of the scheduler: accept, scan, update, report.
// Depends on pps_pkg.
module pps_ctrl
  import pps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       kind,
  input  dp_sts_t    sts,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (kind == KIND_LOAD) begin
            cmd.load_en = 1'b1;
          end else begin
            cmd.scan_clr = 1'b1;
            state_next   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update_en = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish_en = 1'b1;
        state_next    = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

FILE: sv/pps_dp.sv
// Datapath of the scheduler: process table, slot scan, time and result registers.
// Depends on pps_pkg.
module pps_dp
  import pps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  input  ctrl_cmd_t  cmd,
  output dp_sts_t    sts,
  output result_t    result,
  output logic       done
);

  // Process table, no reset: only read where active is set
  logic [15:0] arrive_mem [MAX_PROCS];
  logic [15:0] burst_mem  [MAX_PROCS];
  logic [15:0] left_mem   [MAX_PROCS];
  logic [7:0]  prio_mem   [MAX_PROCS];

  // Slot is loaded and has work remaining
  logic [MAX_PROCS-1:0] active;
  logic [31:0]          now;

  // Scan state
  logic [IDX_W-1:0] scan_idx;
  logic             found;
  logic [IDX_W-1:0] best_idx;
  logic [7:0]       best_prio;
  logic [15:0]      best_arrive;
  logic [15:0]      best_burst;
  logic [15:0]      best_left;

  // Update results
  logic        fin;
  logic [31:0] tat;

  logic [IDX_W-1:0] load_idx;
  logic             load_ok;
  logic             elig;
  logic             take;

  assign load_idx = IDX_W'(item.slot);
  assign load_ok  = ({28'd0, item.slot} < 32'(MAX_PROCS));

  assign elig = active[scan_idx] && ({16'd0, arrive_mem[scan_idx]} <= now);
  assign take = elig && (!found || (prio_mem[scan_idx] < best_prio));

  assign sts.scan_last = (scan_idx == IDX_W'(MAX_PROCS - 1));

  // Write the table on a load, decrement remaining work on update
  always_ff @(posedge clk) begin
    if (cmd.load_en && load_ok) begin
      arrive_mem[load_idx] <= item.arrival;
      burst_mem[load_idx]  <= item.burst;
      left_mem[load_idx]   <= item.burst;
      prio_mem[load_idx]   <= item.prio;
    end else if (cmd.update_en && found) begin
      left_mem[best_idx] <= best_left - 16'd1;
    end
  end

  // Track which slots still have work
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cmd.load_en && load_ok) begin
      active[load_idx] <= (item.burst != 16'd0);
    end else if (cmd.update_en && found && (best_left == 16'd1)) begin
      active[best_idx] <= 1'b0;
    end
  end

  // Scan one slot per cycle, keep the best candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      found    <= 1'b0;
    end else if (cmd.scan_clr) begin
      scan_idx <= '0;
      found    <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + IDX_W'(1);
      if (take) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && take) begin
      best_idx    <= scan_idx;
      best_prio   <= prio_mem[scan_idx];
      best_arrive <= arrive_mem[scan_idx];
      best_burst  <= burst_mem[scan_idx];
      best_left   <= left_mem[scan_idx];
    end
  end

  // Compute completion and turnaround of the chosen slot
  always_ff @(posedge clk) begin
    if (cmd.update_en) begin
      fin <= found && (best_left == 16'd1);
      tat <= now + 32'd1 - {16'd0, best_arrive};
    end
  end

  // Advance time
  always_ff @(posedge clk) begin
    if (rst) begin
      now <= '0;
    end else if (cmd.finish_en) begin
      now <= now + 32'd1;
    end
  end

  // Register the result transaction and its strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_en) begin
      result.ran        <= found;
      result.run_slot   <= found ? 4'(best_idx) : 4'd0;
      result.finished   <= fin;
      result.turnaround <= fin ? tat : 32'd0;
      result.waiting    <= fin ? (tat - {16'd0, best_burst}) : 32'd0;
      result.all_done   <= ~|active;
    end
  end

endmodule

FILE: sv/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler.
// Depends on pps_pkg, pps_ctrl and pps_dp.

// A load transaction (kind 0) writes one process slot and gives no result;
// busy stays low. A tick transaction (kind 1) walks the MAX_PROCS slots one
// per cycle to find the arrived slot with the smallest priority number
// (lowest slot wins ties), then updates that slot in the UPDATE state and
// forms the result in the FINISH state: done pulses for one cycle, registered
// from FINISH, and busy is high through SCAN, UPDATE and FINISH. Results
// must be captured in the cycle done is high; there is no way to hold them
// off. Every tick gives a result, idle ticks included (ran low).
module preemptive_priority_scheduler
  import pps_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  pps_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (item.kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  pps_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result),
    .done   (done)
  );

endmodule
